// ===== rtl/core/text_terminal_cell_engine_macros.svh =====
// Assertion macros shared by the terminal cell engine RTL.
`ifndef TEXT_TERMINAL_CELL_ENGINE_MACROS_SVH
`define TEXT_TERMINAL_CELL_ENGINE_MACROS_SVH

// same-cycle implication
`define TTE_ASSERT_IMP(name, clock, rstn, ante, cons) \
  name: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tte: same-cycle check failed");

// next-cycle implication
`define TTE_ASSERT_NXT(name, clock, rstn, ante, cons) \
  name: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tte: next-cycle check failed");

`endif

// ===== rtl/core/tte_pkg.sv =====
// Shared types and constants of the terminal cell engine.
`timescale 1ns / 1ps
package tte_pkg;

  // line and column arithmetic: 8-bit cursor plus one carry bit
  localparam int LW         = 9;
  localparam int CHAR_W     = 21;
  localparam int COLOR_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [1:0] REQ_CHAR = 2'd0;
  localparam logic [1:0] REQ_CMD  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [3:0] CMD_CLEAR  = 4'd0;
  localparam logic [3:0] CMD_SCROLL = 4'd1;
  localparam logic [3:0] CMD_FG     = 4'd2;
  localparam logic [3:0] CMD_BG     = 4'd3;
  localparam logic [3:0] CMD_COLOR  = 4'd4;
  localparam logic [3:0] CMD_MOVE   = 4'd5;
  localparam logic [3:0] CMD_LINE   = 4'd6;
  localparam logic [3:0] CMD_COL    = 4'd7;
  localparam logic [3:0] CMD_HIDE   = 4'd8;
  localparam logic [3:0] CMD_SHOW   = 4'd9;

  localparam logic [CHAR_W-1:0] CH_BS    = 21'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 21'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 21'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 21'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 21'h20;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

  localparam logic [6:0] ROWS_RESET = 7'd25;
  localparam logic [7:0] COLS_RESET = 8'd80;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] color;
  } cell_t;

  typedef struct packed {
    logic               start;
    logic               fill;    // 1: whole store, 0: shift rows up
    logic [LW-1:0]      shift;   // rows to shift by
    logic [LW-1:0]      rows;
    logic [LW-1:0]      cols;
    logic [COLOR_W-1:0] color;
  } sweep_req_t;

  typedef struct packed {
    logic [7:0]         cursor_row;
    logic [7:0]         cursor_col;
    logic               cursor_hidden;
    logic               cell_written;
    logic [5:0]         written_row;
    logic [6:0]         written_col;
    logic [CHAR_W-1:0]  written_char;
    logic [COLOR_W-1:0] written_color;
    logic               full_refresh;
    logic [CHAR_W-1:0]  read_char;
    logic [COLOR_W-1:0] read_color;
  } res_t;

endpackage

// ===== rtl/core/tte_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface tte_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [20:0] char_code;
  logic [3:0]  command;
  logic [7:0]  arg_a;
  logic [7:0]  arg_b;
  logic [5:0]  read_row;
  logic [6:0]  read_col;

  modport source (output valid, req_type, char_code, command, arg_a, arg_b, read_row,
                  read_col, input ready);
  modport sink (input valid, req_type, char_code, command, arg_a, arg_b, read_row,
                read_col, output ready);
endinterface

interface tte_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cursor_row;
  logic [7:0]  cursor_col;
  logic        cursor_hidden;
  logic        cell_written;
  logic [5:0]  written_row;
  logic [6:0]  written_col;
  logic [20:0] written_char;
  logic [7:0]  written_color;
  logic        full_refresh;
  logic [20:0] read_char;
  logic [7:0]  read_color;

  modport source (output valid, cursor_row, cursor_col, cursor_hidden, cell_written,
                  written_row, written_col, written_char, written_color, full_refresh,
                  read_char, read_color, input ready);
  modport sink (input valid, cursor_row, cursor_col, cursor_hidden, cell_written,
                written_row, written_col, written_char, written_color, full_refresh,
                read_char, read_color, output ready);
endinterface

// ===== rtl/core/tte_cell_mem.sv =====
// Cell store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module tte_cell_mem import tte_pkg::*; #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output cell_t         rd_data
);

  cell_t mem [DEPTH];
  cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/tte_sweep.sv =====
// Grid sweeper: fills the whole store or shifts the visible rows up.
`timescale 1ns / 1ps
module tte_sweep import tte_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  sweep_req_t req,
  output logic       busy,
  output logic       re,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1) +
                ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1) - 1:0] raddr,
  output logic       we,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1) +
                ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1) - 1:0] waddr,
  output cell_t      wdata,
  input  cell_t      rd_data
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS * (1 << CW);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic               active_r;
  logic               fill_r;
  logic [LW-1:0]      n_r;
  logic [LW-1:0]      rows_r;
  logic [LW-1:0]      cols_r;
  logic [COLOR_W-1:0] color_r;
  logic [LW-1:0]      r_r;
  logic [LW-1:0]      c_r;
  logic [AW-1:0]      lin_r;
  logic               wv_r;
  logic               wblank_r;
  logic [AW-1:0]      waddr_r;

  logic [LW-1:0] src;
  logic          src_ok;

  // destination row r takes source row r + n, or blanks past the bottom
  assign src    = r_r + n_r;
  assign src_ok = src < rows_r;

  assign re    = active_r && !fill_r && src_ok;
  assign raddr = {src[RW-1:0], c_r[CW-1:0]};

  assign we    = wv_r;
  assign waddr = waddr_r;
  assign wdata = wblank_r ? '{ch: CH_SPACE, color: color_r} : rd_data;
  assign busy  = active_r || wv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      wv_r     <= 1'b0;
    end else begin
      wv_r <= active_r;
      if (req.start) begin
        active_r <= 1'b1;
        fill_r   <= req.fill;
        n_r      <= req.shift;
        rows_r   <= req.rows;
        cols_r   <= req.cols;
        color_r  <= req.color;
        r_r      <= '0;
        c_r      <= '0;
        lin_r    <= '0;
      end else if (active_r) begin
        if (fill_r) begin
          waddr_r  <= lin_r;
          wblank_r <= 1'b1;
          if (lin_r == LAST) begin
            active_r <= 1'b0;
          end else begin
            lin_r <= lin_r + AW'(1);
          end
        end else begin
          waddr_r  <= {r_r[RW-1:0], c_r[CW-1:0]};
          wblank_r <= !src_ok;
          if (c_r == cols_r - LW'(1)) begin
            c_r <= '0;
            if (r_r == rows_r - LW'(1)) begin
              active_r <= 1'b0;
            end else begin
              r_r <= r_r + LW'(1);
            end
          end else begin
            c_r <= c_r + LW'(1);
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/tte_ctrl.sv =====
// Item sequencer: decode, cursor and color state, config registers, result register.
`timescale 1ns / 1ps
module tte_ctrl import tte_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128,
  parameter int TAB_STOP = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tte_req_if.sink               in_ch,
  tte_res_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output sweep_req_t            sw_req,
  input  logic                  sw_busy,
  output logic                  ct_we,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1) +
                ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1) - 1:0] ct_waddr,
  output cell_t                 ct_wdata,
  output logic                  ct_re,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1) +
                ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1) - 1:0] ct_raddr,
  input  cell_t                 rd_data
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int TAB_N = 256 / TAB_STOP + 1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_CLR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // next tab stop above column c
  function automatic logic [LW-1:0] tab_next(input logic [7:0] c);
    logic [LW-1:0] r;
    r = '0;
    for (int k = TAB_N; k >= 1; k--) begin
      if (LW'(c) < LW'(k * TAB_STOP)) begin
        r = LW'(k * TAB_STOP);
      end
    end
    return r;
  endfunction

  state_t             state_r;
  logic [6:0]         rows_cfg_r;
  logic [7:0]         cols_cfg_r;
  logic [7:0]         line_r;
  logic [7:0]         col_r;
  logic [COLOR_W-1:0] color_r;
  logic               hidden_r;
  logic [1:0]         req_type_r;
  logic [CHAR_W-1:0]  char_r;
  logic [3:0]         cmd_r;
  logic [7:0]         a_r;
  logic [7:0]         b_r;
  logic [5:0]         rrow_r;
  logic [6:0]         rcol_r;
  res_t               res_r;
  logic               rd_ok_r;
  logic               out_valid_r;
  res_t               out_r;

  logic [LW-1:0]      rows_eff;
  logic [LW-1:0]      cols_eff;
  logic [LW-1:0]      l9;
  logic [LW-1:0]      c9;
  logic [LW-1:0]      wc9;
  logic [LW-1:0]      shift9;
  logic               do_wr;
  logic               wr_ok;
  logic [CHAR_W-1:0]  wch;
  logic               sw_start;
  logic               sw_fill;
  logic               refresh;
  logic               rd_ok;
  logic [7:0]         line_nxt;
  logic [7:0]         col_nxt;
  logic [COLOR_W-1:0] color_nxt;
  logic               hidden_nxt;
  res_t               res_nxt;
  res_t               done_res;
  logic               out_free;
  logic [LW-1:0]      line_ext;
  logic [LW-1:0]      rrow_ext;
  logic [LW-1:0]      rcol_ext;

  // registers saturate into 1..MAX
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_eff = LW'(1);
    end else if (LW'(rows_cfg_r) > LW'(MAX_ROWS)) begin
      rows_eff = LW'(MAX_ROWS);
    end else begin
      rows_eff = LW'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols_eff = LW'(1);
    end else if (LW'(cols_cfg_r) > LW'(MAX_COLS)) begin
      cols_eff = LW'(MAX_COLS);
    end else begin
      cols_eff = LW'(cols_cfg_r);
    end
  end

  always_comb begin
    l9         = LW'(line_r);
    c9         = LW'(col_r);
    wc9        = '0;
    shift9     = LW'(1);
    do_wr      = 1'b0;
    wch        = CH_SPACE;
    sw_start   = 1'b0;
    sw_fill    = 1'b0;
    refresh    = 1'b0;
    rd_ok      = 1'b0;
    line_nxt   = line_r;
    col_nxt    = col_r;
    color_nxt  = color_r;
    hidden_nxt = hidden_r;
    unique case (req_type_r)
      REQ_CHAR: begin
        if (char_r == CH_BS) begin
          if (c9 != '0) begin
            c9 = c9 - LW'(1);
          end
          do_wr = 1'b1;
          wc9   = c9;
        end else if (char_r == CH_TAB) begin
          c9 = tab_next(col_r);
        end else if (char_r == CH_CR) begin
          c9 = '0;
        end else if (char_r == CH_LF) begin
          c9 = '0;
          l9 = l9 + LW'(1);
        end else if (char_r >= CH_SPACE) begin
          do_wr = 1'b1;
          wch   = char_r;
          wc9   = c9;
          c9    = c9 + LW'(1);
        end
        if (c9 >= cols_eff) begin
          c9 = '0;
          l9 = l9 + LW'(1);
        end
        // one scroll per line past the bottom, at most a full screen
        if (l9 >= rows_eff) begin
          shift9 = l9 - (rows_eff - LW'(1));
          if (shift9 > rows_eff) begin
            shift9 = rows_eff;
          end
          l9       = rows_eff - LW'(1);
          sw_start = 1'b1;
          refresh  = 1'b1;
        end
        line_nxt = l9[7:0];
        col_nxt  = c9[7:0];
      end
      REQ_CMD: begin
        unique case (cmd_r)
          CMD_CLEAR: begin
            sw_start = 1'b1;
            sw_fill  = 1'b1;
            refresh  = 1'b1;
          end
          CMD_SCROLL: begin
            sw_start = 1'b1;
            refresh  = 1'b1;
          end
          CMD_FG:    color_nxt = {color_r[7:4], a_r[3:0]};
          CMD_BG:    color_nxt = {a_r[3:0], color_r[3:0]};
          CMD_COLOR: color_nxt = {b_r[3:0], a_r[3:0]};
          CMD_MOVE: begin
            line_nxt = a_r;
            col_nxt  = b_r;
          end
          CMD_LINE:  line_nxt = a_r;
          CMD_COL:   col_nxt = a_r;
          CMD_HIDE:  hidden_nxt = 1'b1;
          CMD_SHOW:  hidden_nxt = 1'b0;
          default: ;
        endcase
      end
      REQ_READ: begin
        rd_ok = (LW'(rrow_r) < rows_eff) && (LW'(rcol_r) < cols_eff);
      end
      default: ;
    endcase
  end

  assign wr_ok = do_wr && (LW'(line_r) < rows_eff) && (wc9 < cols_eff);

  always_comb begin
    res_nxt               = '0;
    res_nxt.cursor_row    = line_nxt;
    res_nxt.cursor_col    = col_nxt;
    res_nxt.cursor_hidden = hidden_nxt;
    res_nxt.cell_written  = wr_ok;
    res_nxt.full_refresh  = refresh;
    if (wr_ok) begin
      res_nxt.written_row   = line_r[5:0];
      res_nxt.written_col   = wc9[6:0];
      res_nxt.written_char  = wch;
      res_nxt.written_color = color_r;
    end
  end

  always_comb begin
    done_res = res_r;
    if (rd_ok_r) begin
      done_res.read_char  = rd_data.ch;
      done_res.read_color = rd_data.color;
    end
  end

  assign line_ext = LW'(line_r);
  assign rrow_ext = LW'(rrow_r);
  assign rcol_ext = LW'(rcol_r);

  assign ct_we    = (state_r == ST_EXEC) && wr_ok;
  assign ct_waddr = {line_ext[RW-1:0], wc9[CW-1:0]};
  assign ct_wdata = '{ch: wch, color: color_r};
  assign ct_re    = (state_r == ST_EXEC) && rd_ok;
  assign ct_raddr = {rrow_ext[RW-1:0], rcol_ext[CW-1:0]};

  // the reset clear uses the sweeper in fill mode with the reset color
  always_comb begin
    sw_req.start = (state_r == ST_INIT) || ((state_r == ST_EXEC) && sw_start);
    sw_req.fill  = (state_r == ST_INIT) || sw_fill;
    sw_req.shift = shift9;
    sw_req.rows  = rows_eff;
    sw_req.cols  = cols_eff;
    sw_req.color = color_r;
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      rows_cfg_r  <= ROWS_RESET;
      cols_cfg_r  <= COLS_RESET;
      line_r      <= '0;
      col_r       <= '0;
      color_r     <= COLOR_RESET;
      hidden_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_ROWS: rows_cfg_r <= cfg_data[6:0];
          REG_COLS: cols_cfg_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_INIT: state_r <= ST_CLR;
        ST_CLR: begin
          if (!sw_busy) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_ch.valid) begin
            req_type_r <= in_ch.req_type;
            char_r     <= in_ch.char_code;
            cmd_r      <= in_ch.command;
            a_r        <= in_ch.arg_a;
            b_r        <= in_ch.arg_b;
            rrow_r     <= in_ch.read_row;
            rcol_r     <= in_ch.read_col;
            state_r    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          line_r   <= line_nxt;
          col_r    <= col_nxt;
          color_r  <= color_nxt;
          hidden_r <= hidden_nxt;
          res_r    <= res_nxt;
          rd_ok_r  <= rd_ok;
          if (sw_start) begin
            state_r <= ST_SWEEP;
          end else if (req_type_r == REQ_READ) begin
            state_r <= ST_DONE;
          end else if (out_free) begin
            out_r       <= res_nxt;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_SWEEP: begin
          if (!sw_busy) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_r       <= done_res;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.cursor_row    = out_r.cursor_row;
  assign out_ch.cursor_col    = out_r.cursor_col;
  assign out_ch.cursor_hidden = out_r.cursor_hidden;
  assign out_ch.cell_written  = out_r.cell_written;
  assign out_ch.written_row   = out_r.written_row;
  assign out_ch.written_col   = out_r.written_col;
  assign out_ch.written_char  = out_r.written_char;
  assign out_ch.written_color = out_r.written_color;
  assign out_ch.full_refresh  = out_r.full_refresh;
  assign out_ch.read_char     = out_r.read_char;
  assign out_ch.read_color    = out_r.read_color;

endmodule

// ===== rtl/core/text_terminal_cell_engine.sv =====
// Top level of the text terminal cell engine: sequencer, sweeper and cell store.
// Results are registered out of EXEC, or out of DONE after a read, a sweep or a full output.
// Scroll first sweeps rows_in_use * cols_in_use cells (one cell per cycle on the store port).
// Clear sweeps MAX_ROWS * 2^ceil(log2(MAX_COLS)) cells; no new item is taken before the last result.
// After reset the store is swept to spaces in color 0x07 (8192 cells at the defaults);
// no item is taken during that pass, configuration writes are.
`timescale 1ns / 1ps
`include "text_terminal_cell_engine_macros.svh"
module text_terminal_cell_engine import tte_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128,
  parameter int TAB_STOP = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tte_req_if.sink               in_ch,
  tte_res_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS * (1 << CW);

  sweep_req_t    sw_req;
  logic          sw_busy;
  logic          sw_re;
  logic [AW-1:0] sw_raddr;
  logic          sw_we;
  logic [AW-1:0] sw_waddr;
  cell_t         sw_wdata;
  logic          ct_we;
  logic [AW-1:0] ct_waddr;
  cell_t         ct_wdata;
  logic          ct_re;
  logic [AW-1:0] ct_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  cell_t         rd_data;

  tte_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .TAB_STOP (TAB_STOP)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .sw_req   (sw_req),
    .sw_busy  (sw_busy),
    .ct_we    (ct_we),
    .ct_waddr (ct_waddr),
    .ct_wdata (ct_wdata),
    .ct_re    (ct_re),
    .ct_raddr (ct_raddr),
    .rd_data  (rd_data)
  );

  tte_sweep #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sw_req),
    .busy    (sw_busy),
    .re      (sw_re),
    .raddr   (sw_raddr),
    .we      (sw_we),
    .waddr   (sw_waddr),
    .wdata   (sw_wdata),
    .rd_data (rd_data)
  );

  // the sweeper owns the store port while it runs
  assign mem_we    = sw_busy ? sw_we    : ct_we;
  assign mem_waddr = sw_busy ? sw_waddr : ct_waddr;
  assign mem_wdata = sw_busy ? sw_wdata : ct_wdata;
  assign mem_re    = sw_busy ? sw_re    : ct_re;
  assign mem_raddr = sw_busy ? sw_raddr : ct_raddr;

  tte_cell_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rd_data (rd_data)
  );

  `TTE_ASSERT_IMP(a_no_accept_in_sweep, clk, rst_n, in_ch.valid && in_ch.ready, !sw_busy)
  `TTE_ASSERT_IMP(a_ctrl_write_excl, clk, rst_n, ct_we || ct_re, !sw_busy)
  `TTE_ASSERT_NXT(a_one_item_in_flight, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule

// ===== bench/tte_result_checker.sv =====
// Result checker for the terminal cell engine: mirrors grid, cursor and color, compares results.
`timescale 1ns / 1ps
module tte_result_checker import tte_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128,
  parameter int TAB_STOP = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tte_req_if                    req,
  tte_res_if                    res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;

  logic [CHAR_W-1:0]  grid_char  [0:CELLS-1];
  logic [COLOR_W-1:0] grid_color [0:CELLS-1];
  int unsigned        cur_line;
  int unsigned        cur_col;
  logic [COLOR_W-1:0] pen_color;
  logic               hidden;
  logic [6:0]         rows_reg;
  logic [7:0]         cols_reg;
  res_t               expected_results [$];

  function automatic int unsigned grid_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int unsigned grid_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return cols_reg;
  endfunction

  // whole store, visible or not
  function automatic void fill_grid();
    int i;
    for (i = 0; i < CELLS; i++) begin
      grid_char[i]  = CH_SPACE;
      grid_color[i] = pen_color;
    end
  endfunction

  function automatic void scroll_grid();
    int unsigned nr, nc, r, c;
    nr = grid_rows();
    nc = grid_cols();
    for (r = 0; r + 1 < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        grid_char[r*MAX_COLS+c]  = grid_char[(r+1)*MAX_COLS+c];
        grid_color[r*MAX_COLS+c] = grid_color[(r+1)*MAX_COLS+c];
      end
    end
    for (c = 0; c < nc; c++) begin
      grid_char[(nr-1)*MAX_COLS+c]  = CH_SPACE;
      grid_color[(nr-1)*MAX_COLS+c] = pen_color;
    end
  endfunction

  // off-grid writes are dropped
  function automatic void put_cell(input int unsigned row, input int unsigned col,
                                   input logic [CHAR_W-1:0] ch, inout res_t r);
    if (row >= grid_rows() || col >= grid_cols()) return;
    grid_char[row*MAX_COLS+col]  = ch;
    grid_color[row*MAX_COLS+col] = pen_color;
    r.cell_written  = 1'b1;
    r.written_row   = row[5:0];
    r.written_col   = col[6:0];
    r.written_char  = ch;
    r.written_color = pen_color;
  endfunction

  function automatic res_t predict_terminal_step(input logic [1:0] kind,
                                                 input logic [CHAR_W-1:0] ch,
                                                 input logic [3:0] cmd,
                                                 input logic [7:0] a, input logic [7:0] b,
                                                 input logic [5:0] rr, input logic [6:0] rc);
    res_t r;
    int unsigned nr, nc, line, col, n, i;
    r = '0;
    nr = grid_rows();
    nc = grid_cols();
    case (kind)
      REQ_CHAR: begin
        line = cur_line;
        col = cur_col;
        if (ch == CH_BS) begin
          if (col > 0) col--;
          put_cell(line, col, CH_SPACE, r);
        end else if (ch == CH_TAB) begin
          col = col + TAB_STOP - (col % TAB_STOP);
        end else if (ch == CH_CR) begin
          col = 0;
        end else if (ch == CH_LF) begin
          col = 0;
          line++;
        end else if (ch >= CH_SPACE) begin
          put_cell(line, col, ch, r);
          col++;
        end
        if (col >= nc) begin
          col = 0;
          line++;
        end
        // one scroll per line past the bottom, never more than the grid height
        if (line >= nr) begin
          n = line - (nr - 1);
          if (n > nr) n = nr;
          for (i = 0; i < n; i++) scroll_grid();
          line = nr - 1;
          r.full_refresh = 1'b1;
        end
        cur_line = line & 8'hFF;
        cur_col  = col & 8'hFF;
      end
      REQ_CMD: begin
        case (cmd)
          CMD_CLEAR: begin
            fill_grid();
            r.full_refresh = 1'b1;
          end
          CMD_SCROLL: begin
            scroll_grid();
            r.full_refresh = 1'b1;
          end
          CMD_FG:    pen_color = {pen_color[7:4], a[3:0]};
          CMD_BG:    pen_color = {a[3:0], pen_color[3:0]};
          CMD_COLOR: pen_color = {b[3:0], a[3:0]};
          CMD_MOVE: begin
            cur_line = a;
            cur_col  = b;
          end
          CMD_LINE:  cur_line = a;
          CMD_COL:   cur_col = a;
          CMD_HIDE:  hidden = 1'b1;
          CMD_SHOW:  hidden = 1'b0;
          default: ;
        endcase
      end
      REQ_READ: begin
        if (rr < nr && rc < nc) begin
          r.read_char  = grid_char[rr*MAX_COLS+rc];
          r.read_color = grid_color[rr*MAX_COLS+rc];
        end
      end
      default: ;
    endcase
    r.cursor_row    = cur_line[7:0];
    r.cursor_col    = cur_col[7:0];
    r.cursor_hidden = hidden;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      pen_color = COLOR_RESET;
      cur_line  = 0;
      cur_col   = 0;
      hidden    = 1'b0;
      rows_reg  = ROWS_RESET;
      cols_reg  = COLS_RESET;
      fill_grid();
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_ROWS: rows_reg = cfg_data[6:0];
          REG_COLS: cols_reg = cfg_data;
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with no item outstanding, expected none actual row 0x%0h col 0x%0h",
                   $time, res.cursor_row, res.cursor_col);
        end else begin
          want = expected_results.pop_front();
          check_field("cursor_row", want.cursor_row, res.cursor_row);
          check_field("cursor_col", want.cursor_col, res.cursor_col);
          check_field("cursor_hidden", want.cursor_hidden, res.cursor_hidden);
          check_field("cell_written", want.cell_written, res.cell_written);
          check_field("written_row", want.written_row, res.written_row);
          check_field("written_col", want.written_col, res.written_col);
          check_field("written_char", want.written_char, res.written_char);
          check_field("written_color", want.written_color, res.written_color);
          check_field("full_refresh", want.full_refresh, res.full_refresh);
          check_field("read_char", want.read_char, res.read_char);
          check_field("read_color", want.read_color, res.read_color);
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(predict_terminal_step(req.req_type, req.char_code,
                                                         req.command, req.arg_a, req.arg_b,
                                                         req.read_row, req.read_col));
    end
    pending <= expected_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Bench top for the terminal cell engine: clock, reset, stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module testbench;
  import tte_pkg::*;

  localparam int STALL_LIMIT = 100000;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES  = 11;

  typedef struct packed {
    logic [1:0]         kind;
    logic [CHAR_W-1:0]  ch;
    logic [3:0]         cmd;
    logic [7:0]         a;
    logic [7:0]         b;
    logic [5:0]         rr;
    logic [6:0]         rc;
  } req_item_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    send_mode;
  int                    recv_mode;
  bit                    hold_off_req;
  int                    stall_count;
  int                    rows_now;
  int                    cols_now;

  // per phase: raw register values, item count, sender and receiver pacing, hold-off
  int ph_rows  [NUM_PHASES] = '{3, 4, 8, 0, 1, 64, 25, 127, 6, 2, 5};
  int ph_cols  [NUM_PHASES] = '{7, 10, 16, 0, 255, 2, 80, 255, 128, 3, 5};
  int ph_items [NUM_PHASES] = '{120, 60, 120, 60, 80, 100, 80, 40, 80, 100, 60};
  int ph_send  [NUM_PHASES] = '{1, 0, 0, 2, 1, 2, 1, 2, 2, 1, 0};
  int ph_recv  [NUM_PHASES] = '{1, 1, 0, 2, 2, 1, 1, 2, 0, 1, 2};
  bit ph_hold  [NUM_PHASES] = '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  tte_req_if req_ch ();
  tte_res_if res_ch ();

  text_terminal_cell_engine u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_ch),
    .out_ch  (res_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  tte_result_checker u_result_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_ch),
    .res     (res_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mode 0: no gaps, 1: a random gap, possibly none, before every item, 2: occasional gaps
  function automatic int draw_gap(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 17);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stall_count <= 0;
      end else if (stall_count + 1 >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      gap = draw_gap(recv_mode);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid === 1'b1 && res_ch.ready === 1'b1));
    end
  end

  task automatic push_item(input req_item_t it);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= it.kind;
    req_ch.char_code <= it.ch;
    req_ch.command   <= it.cmd;
    req_ch.arg_a     <= it.a;
    req_ch.arg_b     <= it.b;
    req_ch.read_row  <= it.rr;
    req_ch.read_col  <= it.rc;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // unused fields carry random content
  function automatic req_item_t noise_item();
    req_item_t it;
    it.kind = $urandom_range(0, 2);
    it.ch   = $urandom_range(0, 1114111);
    it.cmd  = $urandom_range(0, 9);
    it.a    = $urandom_range(0, 255);
    it.b    = $urandom_range(0, 255);
    it.rr   = $urandom_range(0, 63);
    it.rc   = $urandom_range(0, 127);
    return it;
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] ch);
    req_item_t it;
    it = noise_item();
    it.kind = REQ_CHAR;
    it.ch = ch;
    push_item(it);
  endtask

  task automatic send_command(input logic [3:0] cmd, input logic [7:0] a, input logic [7:0] b);
    req_item_t it;
    it = noise_item();
    it.kind = REQ_CMD;
    it.cmd = cmd;
    it.a = a;
    it.b = b;
    push_item(it);
  endtask

  task automatic send_read(input logic [5:0] rr, input logic [6:0] rc);
    req_item_t it;
    it = noise_item();
    it.kind = REQ_READ;
    it.rr = rr;
    it.rc = rc;
    push_item(it);
  endtask

  // cursor placement: near the grid mostly; on big grids kept inside to bound scroll cost
  function automatic logic [7:0] pick_pos(input int span, input bit big);
    if (big) return $urandom_range(0, (span > 1) ? span - 2 : 0);
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, span + 1);
    return $urandom_range(0, 255);
  endfunction

  function automatic req_item_t random_item();
    req_item_t it;
    int pick;
    bit big;
    it = noise_item();
    big = (rows_now * cols_now) > 256;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      if (big) begin
        it.kind = REQ_READ;
      end
    end else if (pick < 50) begin
      it.kind = REQ_CHAR;
      it.ch = ($urandom_range(0, 2) != 0) ? $urandom_range(32, 126) : $urandom_range(32, 1114111);
    end else if (pick < 62) begin
      it.kind = REQ_CHAR;
      case ($urandom_range(0, 4))
        0: it.ch = CH_BS;
        1: it.ch = CH_TAB;
        2: it.ch = CH_CR;
        3: it.ch = CH_LF;
        default: it.ch = $urandom_range(0, 31);
      endcase
    end else if (pick < 80) begin
      it.kind = REQ_CMD;
      if (pick == 62) begin
        it.cmd = CMD_CLEAR;
      end else if (pick < 65) begin
        it.cmd = big ? CMD_SHOW : CMD_SCROLL;
      end else begin
        case ($urandom_range(0, 8))
          0: it.cmd = CMD_FG;
          1: it.cmd = CMD_BG;
          2: it.cmd = CMD_COLOR;
          3, 4: begin
            it.cmd = CMD_MOVE;
            it.a = pick_pos(rows_now, big);
            it.b = pick_pos(cols_now, big);
          end
          5: begin
            it.cmd = CMD_LINE;
            it.a = pick_pos(rows_now, big);
          end
          6: begin
            it.cmd = CMD_COL;
            it.a = pick_pos(cols_now, big);
          end
          7: it.cmd = CMD_HIDE;
          default: it.cmd = CMD_SHOW;
        endcase
      end
    end else begin
      it.kind = REQ_READ;
      if ($urandom_range(0, 9) < 7) begin
        it.rr = $urandom_range(0, (rows_now < 63) ? rows_now : 63);
        it.rc = $urandom_range(0, (cols_now < 127) ? cols_now : 127);
      end
    end
    return it;
  endfunction

  task automatic write_grid_size(input int r, input int c);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_ROWS;
    cfg_data <= r[7:0];
    @(posedge clk);
    cfg_idx  <= REG_COLS;
    cfg_data <= c[7:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    rows_now = (r == 0) ? 1 : ((r > 64) ? 64 : r);
    cols_now = (c == 0) ? 1 : ((c > 128) ? 128 : c);
  endtask

  task automatic drain();
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int ph;
    int k;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= REG_ROWS;
    cfg_data         <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_CHAR;
    req_ch.char_code <= '0;
    req_ch.command   <= CMD_CLEAR;
    req_ch.arg_a     <= '0;
    req_ch.arg_b     <= '0;
    req_ch.read_row  <= '0;
    req_ch.read_col  <= '0;
    hold_off_req = 1'b0;
    stall_count = 0;
    send_mode = 1;
    recv_mode = 1;
    rows_now = ROWS_RESET;
    cols_now = COLS_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset-size grid: last cell inside, first row outside
    send_read(6'd24, 7'd79);
    send_read(6'd25, 7'd0);
    req_ch.valid <= 1'b0;
    drain();
    write_grid_size(4, 10);

    send_char(21'h41);
    send_char(21'h10FFFF);
    send_char(21'h0);
    send_command(CMD_FG, 8'hFF, 8'h00);
    send_command(CMD_BG, 8'hA5, 8'h00);
    send_command(CMD_COLOR, 8'h12, 8'hF3);
    send_char(CH_TAB);
    send_char(21'h7A);
    send_char(21'h79);                    // wraps to next line
    send_char(CH_BS);                     // at column 0
    send_char(CH_LF);
    send_command(CMD_MOVE, 8'd3, 8'd9);
    send_char(21'h21);                    // last cell, wrap forces a scroll
    send_read(6'd2, 7'd9);
    send_read(6'd63, 7'd127);             // outside the grid
    send_command(CMD_MOVE, 8'd255, 8'd255);
    send_char(21'h78);                    // off-grid write, far past the bottom
    send_command(CMD_LINE, 8'd200, 8'd0);
    send_char(CH_CR);
    send_command(CMD_COL, 8'd7, 8'd0);
    send_char(21'h1F);
    send_command(CMD_SCROLL, 8'd0, 8'd0);
    send_command(CMD_HIDE, 8'd0, 8'd0);
    send_char(21'h68);
    send_command(CMD_SHOW, 8'd0, 8'd0);
    send_command(CMD_CLEAR, 8'd0, 8'd0);
    send_read(6'd0, 7'd0);
    send_char(CH_BS);
    req_ch.valid <= 1'b0;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_grid_size(ph_rows[ph], ph_cols[ph]);
      send_mode = ph_send[ph];
      recv_mode = ph_recv[ph];
      if (ph_hold[ph]) hold_off_req = 1'b1;
      for (k = 0; k < ph_items[ph]; k++) push_item(random_item());
      req_ch.valid <= 1'b0;
    end

    drain();
    repeat (32) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tte_pkg.sv
rtl/core/tte_if.sv
rtl/core/tte_cell_mem.sv
rtl/core/tte_sweep.sv
rtl/core/tte_ctrl.sv
rtl/core/text_terminal_cell_engine.sv
bench/tte_result_checker.sv
bench/testbench.sv
